[hdl/sirs_pkg.sv]
// shared types and constants of the radix symbol converter
`default_nettype none

package sirs_pkg;

   localparam int VALUE_W    = 32;
   localparam int MAG_W      = 32;
   localparam int SYM_W      = 8;
   localparam int BASE_W     = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;
   localparam int MAX_DIGITS = 32;
   localparam int CNT_W      = 6;
   localparam int PTR_W      = 5;
   localparam int STEP_BITS  = 8;
   localparam int NSTEPS     = MAG_W / STEP_BITS;
   localparam int STEP_CNT_W = 2;
   localparam int NUM_SLOTS  = 16;
   localparam int SLOT_W     = 4;

   localparam logic [CSR_IDX_W-1:0] REG_BASE_SIZE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

   localparam logic [SYM_W-1:0] MINUS_SYM = 8'h2D;
   localparam logic [SYM_W-1:0] PLUS_SYM  = 8'h2B;
   localparam logic [SYM_W-1:0] SPACE_SYM = 8'h20;
   localparam logic [SYM_W-1:0] CTRL_LO   = 8'd9;
   localparam logic [SYM_W-1:0] CTRL_HI   = 8'd13;

   localparam logic [BASE_W-1:0] MIN_BASE = 5'd2;

   typedef struct packed {
      logic load;
      logic div_step;
      logic div_first;
      logic push;
      logic out_sign;
      logic out_digit;
   } cmd_type;

   typedef struct packed {
      logic base_ok;
      logic mag_zero;
      logic neg;
      logic one_left;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

[hdl/sirs_req_if.sv]
// request channel carrying the signed value
`default_nettype none

interface sirs_req_if;
   import sirs_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

[hdl/sirs_rsp_if.sv]
// result channel carrying the symbols of each request, one symbol per transfer
`default_nettype none

interface sirs_rsp_if;
   import sirs_pkg::*;

   logic             valid;
   logic             ready;
   logic [SYM_W-1:0] symbol;
   logic             last;

   modport source (output valid, output symbol, output last, input ready);
   modport sink   (input valid, input symbol, input last, output ready);
endinterface

`default_nettype wire

[hdl/sirs_csr_if.sv]
// register write channel
`default_nettype none

interface sirs_csr_if;
   import sirs_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hdl/signed_integer_to_radix_symbols.sv]
// top level of the signed integer to radix symbol converter
`default_nettype none

// converts each signed 32-bit request into its digits in a programmable base of
// 2 to MAX_BASE symbols, most significant digit first, one 8-bit symbol per
// result, with a leading minus symbol for negative values and last set on the
// final digit; zero gives the single symbol of digit 0, and the most negative
// value converts exactly. if the alphabet held in the registers is unusable
// (fewer than two symbols, more than MAX_BASE, a plus, minus, space or byte
// 9 to 13 among them, or a repeated symbol) a request gives no result at all.
// registers: 0 base_size (low 5 bits), 1 symbols of digits 0 to 7, 2 of digits
// 8 to 15, digit n in byte n mod 8; other indexes are ignored; all reset to 0.
// write them only while no request is in flight. one request is worked at a
// time: the request is taken, the alphabet is checked, then each digit comes from
// the shared divider (4 passes of 8 quotient bits plus a zero test), then one
// symbol is emitted per cycle while the result side keeps up. the last symbol
// sits in the output register while the next request is already taken.

module signed_integer_to_radix_symbols #(
   parameter int MAX_BASE = 16
) (
   input  logic              clock,
   input  logic              reset,
   sirs_req_if.sink          req_ch,
   sirs_rsp_if.source        rsp_ch,
   sirs_csr_if.sink          csr_ch
);
   import sirs_pkg::*;

   cmd_type    cmd;
   status_type status;

   // register writes are always taken
   assign csr_ch.ready = 1'b1;

   // sequencer: owns the request handshake and the per digit loop
   sirs_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: registers, alphabet check, divider, digit stack, output stage
   sirs_datapath #(
      .MAX_BASE (MAX_BASE)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .value      (req_ch.value),
      .csr_valid  (csr_ch.valid),
      .csr_index  (csr_ch.index),
      .csr_data   (csr_ch.data),
      .cmd        (cmd),
      .status     (status),
      .rsp_valid  (rsp_ch.valid),
      .rsp_symbol (rsp_ch.symbol),
      .rsp_last   (rsp_ch.last),
      .rsp_ready  (rsp_ch.ready)
   );

endmodule

`default_nettype wire

[hdl/sirs_datapath.sv]
// registers, alphabet check, shared radix divider, digit stack and output register
`default_nettype none

module sirs_datapath #(
   parameter int MAX_BASE = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic signed [sirs_pkg::VALUE_W-1:0] value,
   input  logic                                csr_valid,
   input  logic [sirs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sirs_pkg::CSR_DATA_W-1:0]     csr_data,
   input  sirs_pkg::cmd_type                   cmd,
   output sirs_pkg::status_type                status,
   output logic                                rsp_valid,
   output logic [sirs_pkg::SYM_W-1:0]          rsp_symbol,
   output logic                                rsp_last,
   input  logic                                rsp_ready
);
   import sirs_pkg::*;

   localparam int DIGIT_W = $clog2(MAX_BASE);

   logic [BASE_W-1:0]     base_size_ff;
   logic [CSR_DATA_W-1:0] symbols_low_ff;
   logic [CSR_DATA_W-1:0] symbols_high_ff;
   logic                  base_ok_ff;
   logic                  base_ok_in;
   logic [SYM_W-1:0]      sym_tab [NUM_SLOTS];

   logic                  neg_ff;
   logic [MAG_W-1:0]      work_ff;
   logic [MAG_W-1:0]      work_in;
   logic [BASE_W-1:0]     rem_ff;
   logic [BASE_W-1:0]     rem_in;
   logic [MAG_W-1:0]      mag_in;
   logic [CNT_W-1:0]      cnt_ff;
   logic [CNT_W-1:0]      top_idx;
   logic [DIGIT_W-1:0]    stack_ff [MAX_DIGITS];

   logic                  rsp_valid_ff;
   logic [SYM_W-1:0]      rsp_symbol_ff;
   logic                  rsp_last_ff;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         base_size_ff    <= '0;
         symbols_low_ff  <= '0;
         symbols_high_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_BASE_SIZE:    base_size_ff    <= csr_data[BASE_W-1:0];
            REG_SYMBOLS_LOW:  symbols_low_ff  <= csr_data;
            REG_SYMBOLS_HIGH: symbols_high_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_SLOTS / 2; i++) begin
         sym_tab[i]                 = symbols_low_ff[i*SYM_W +: SYM_W];
         sym_tab[i + NUM_SLOTS / 2] = symbols_high_ff[i*SYM_W +: SYM_W];
      end
   end

   // alphabet check, all comparisons side by side
   always_comb begin
      base_ok_in = (base_size_ff >= MIN_BASE) && (base_size_ff <= BASE_W'(MAX_BASE));
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (BASE_W'(i) < base_size_ff) begin
            if (sym_tab[i] == PLUS_SYM || sym_tab[i] == MINUS_SYM ||
                sym_tab[i] == SPACE_SYM ||
                (sym_tab[i] >= CTRL_LO && sym_tab[i] <= CTRL_HI))
               base_ok_in = 1'b0;
            for (int j = i + 1; j < NUM_SLOTS; j++) begin
               if (BASE_W'(j) < base_size_ff && sym_tab[j] == sym_tab[i])
                  base_ok_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ok_ff <= 1'b0;
      end else begin
         base_ok_ff <= base_ok_in;
      end
   end

   // magnitude, unsigned so the most negative value survives
   assign mag_in = value[VALUE_W-1] ? (~$unsigned(value) + 1'b1) : $unsigned(value);

   // eight quotient bits per step, dividend shifts out at the top
   always_comb begin
      rem_in  = cmd.div_first ? '0 : rem_ff;
      work_in = work_ff;
      for (int k = 0; k < STEP_BITS; k++) begin
         rem_in  = {rem_in[BASE_W-2:0], work_in[MAG_W-1]};
         work_in = {work_in[MAG_W-2:0], 1'b0};
         if (rem_in >= base_size_ff) begin
            rem_in     = rem_in - base_size_ff;
            work_in[0] = 1'b1;
         end
      end
   end

   assign top_idx = cnt_ff - 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         neg_ff  <= value[VALUE_W-1];
         work_ff <= mag_in;
      end else if (cmd.div_step) begin
         work_ff <= work_in;
         rem_ff  <= rem_in;
      end
      if (cmd.push) begin
         stack_ff[cnt_ff[PTR_W-1:0]] <= rem_in[DIGIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.load) begin
         cnt_ff <= '0;
      end else if (cmd.push) begin
         cnt_ff <= cnt_ff + 1'b1;
      end else if (cmd.out_digit) begin
         cnt_ff <= top_idx;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_sign || cmd.out_digit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_sign) begin
         rsp_symbol_ff <= MINUS_SYM;
         rsp_last_ff   <= 1'b0;
      end else if (cmd.out_digit) begin
         rsp_symbol_ff <= sym_tab[SLOT_W'(stack_ff[top_idx[PTR_W-1:0]])];
         rsp_last_ff   <= (cnt_ff == CNT_W'(1));
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_symbol = rsp_symbol_ff;
   assign rsp_last   = rsp_last_ff;

   assign status.base_ok  = base_ok_ff;
   assign status.mag_zero = (work_ff == '0);
   assign status.neg      = neg_ff;
   assign status.one_left = (cnt_ff == CNT_W'(1));
   assign status.out_free = !rsp_valid_ff || rsp_ready;

endmodule

`default_nettype wire

[hdl/sirs_controller.sv]
// sequencer: accept, check alphabet, divide per digit, emit sign and digits
`default_nettype none

module sirs_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  sirs_pkg::status_type status,
   output sirs_pkg::cmd_type    cmd
);
   import sirs_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_TEST  = 3'd3;
   localparam logic [2:0] ST_SIGN  = 3'd4;
   localparam logic [2:0] ST_EMIT  = 3'd5;

   logic [2:0]            state_ff;
   logic [2:0]            state_in;
   logic [STEP_CNT_W-1:0] step_ff;
   logic [STEP_CNT_W-1:0] step_in;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            step_in  = '0;
            state_in = status.base_ok ? ST_DIV : ST_IDLE;
         end
         ST_DIV: begin
            cmd.div_step  = 1'b1;
            cmd.div_first = (step_ff == '0);
            step_in       = step_ff + 1'b1;
            if (step_ff == STEP_CNT_W'(NSTEPS - 1)) begin
               cmd.push = 1'b1;
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            if (!status.mag_zero) begin
               state_in = ST_DIV;
            end else begin
               state_in = status.neg ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (status.out_free) begin
               cmd.out_sign = 1'b1;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.out_digit = 1'b1;
               if (status.one_left) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

`default_nettype wire
